### sv/sgs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgs_pkg: shared types and constants of the savitzky-golay smoother
// tap tables, word widths and the rounded reciprocals of both divisors
// ----------------------------------------------------------------------------
package sgs_pkg;

    localparam int SAMPLE_BITS     = 16;
    localparam int RECIP_FRAC_BITS = 24;
    localparam int NUM_CELLS       = 9;
    localparam int TAP_W           = 9;
    localparam int SUM_W           = SAMPLE_BITS + 10;
    localparam int RECIP_W         = 21;
    localparam int PROD_W          = SUM_W + RECIP_W;
    localparam int ROUND_W         = PROD_W - RECIP_FRAC_BITS;

    localparam longint DIV7 = 21;
    localparam longint DIV9 = 429;
    localparam longint RECIP7 = ((longint'(1) << RECIP_FRAC_BITS) + DIV7 / 2) / DIV7;
    localparam longint RECIP9 = ((longint'(1) << RECIP_FRAC_BITS) + DIV9 / 2) / DIV9;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [TAP_W-1:0]       tap_t;
    typedef logic signed [SUM_W-1:0]       sum_t;
    typedef logic signed [RECIP_W-1:0]     recip_t;
    typedef logic signed [PROD_W-1:0]      prod_t;
    typedef logic signed [ROUND_W-1:0]     round_t;

    typedef enum logic
    {
        FILTER_CUBIC7   = 1'b0,
        FILTER_QUINTIC9 = 1'b1
    } filter_t;

    localparam recip_t RECIP7_C = RECIP_W'(RECIP7);
    localparam recip_t RECIP9_C = RECIP_W'(RECIP9);

    // cubic taps, zero past the seventh cell
    function automatic tap_t tap7(input int k);
        tap_t t;
        case (k)
            0:       t = -9'sd2;
            1:       t = 9'sd3;
            2:       t = 9'sd6;
            3:       t = 9'sd7;
            4:       t = 9'sd6;
            5:       t = 9'sd3;
            6:       t = -9'sd2;
            default: t = 9'sd0;
        endcase
        return t;
    endfunction

    function automatic tap_t tap9(input int k);
        tap_t t;
        case (k)
            0:       t = 9'sd15;
            1:       t = -9'sd55;
            2:       t = 9'sd30;
            3:       t = 9'sd135;
            4:       t = 9'sd179;
            5:       t = 9'sd135;
            6:       t = 9'sd30;
            7:       t = -9'sd55;
            8:       t = 9'sd15;
            default: t = 9'sd0;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

### sv/sgs_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgs_cell: one cell of the transposed filter chain
// holds one partial sum per filter and adds its tap product to the neighbor's
// ----------------------------------------------------------------------------
module sgs_cell
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            shift_en,
    input  wire sgs_pkg::sample_t sample,
    input  wire sgs_pkg::tap_t   tap7,
    input  wire sgs_pkg::tap_t   tap9,
    input  wire sgs_pkg::sum_t   acc7_in,
    input  wire sgs_pkg::sum_t   acc9_in,
    output sgs_pkg::sum_t        acc7,
    output sgs_pkg::sum_t        acc9
);
    import sgs_pkg::*;

    sum_t acc7_reg, acc7_next;
    sum_t acc9_reg, acc9_next;

    always_comb
    begin
        acc7_next = (SUM_W'(tap7) * SUM_W'(sample)) + acc7_in;
        acc9_next = (SUM_W'(tap9) * SUM_W'(sample)) + acc9_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc7_reg <= '0;
            acc9_reg <= '0;
        end
        else if (shift_en)
        begin
            acc7_reg <= acc7_next;
            acc9_reg <= acc9_next;
        end
    end

    assign acc7 = acc7_reg;
    assign acc9 = acc9_reg;

endmodule
`default_nettype wire

### sv/sgs_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgs_scaler: reciprocal scaling, rounding and saturation
// multiplies the tap sum by the rounded reciprocal, then rounds and clips
// ----------------------------------------------------------------------------
module sgs_scaler
(
    input  wire logic             clk,
    input  wire logic             advance,
    input  wire sgs_pkg::filter_t filter_sel,
    input  wire sgs_pkg::sum_t    tap_sum,
    output sgs_pkg::sample_t      smoothed_out,
    output logic                  clipped
);
    import sgs_pkg::*;

    localparam round_t SAT_MAX = ROUND_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
    localparam round_t SAT_MIN = -SAT_MAX - ROUND_W'(1);
    localparam prod_t  HALF    = PROD_W'(longint'(1) << (RECIP_FRAC_BITS - 1));

    recip_t  recip;
    prod_t   prod_reg, prod_next;
    prod_t   rounded;
    round_t  y;
    sample_t smoothed_reg, smoothed_next;
    logic    clipped_reg, clipped_next;

    always_comb
    begin
        case (filter_sel)
            FILTER_CUBIC7:   recip = RECIP7_C;
            FILTER_QUINTIC9: recip = RECIP9_C;
            default:         recip = RECIP7_C;
        endcase
        prod_next = PROD_W'(tap_sum) * PROD_W'(recip);
    end

    always_comb
    begin
        rounded = prod_reg + HALF;
        y       = rounded[PROD_W-1:RECIP_FRAC_BITS];
        if (y > SAT_MAX)
        begin
            smoothed_next = SAMPLE_BITS'(SAT_MAX);
            clipped_next  = 1'b1;
        end
        else if (y < SAT_MIN)
        begin
            smoothed_next = SAMPLE_BITS'(SAT_MIN);
            clipped_next  = 1'b1;
        end
        else
        begin
            smoothed_next = y[SAMPLE_BITS-1:0];
            clipped_next  = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_reg     <= prod_next;
            smoothed_reg <= smoothed_next;
            clipped_reg  <= clipped_next;
        end
    end

    assign smoothed_out = smoothed_reg;
    assign clipped      = clipped_reg;

endmodule
`default_nettype wire

### sv/savitzky_golay_smoother_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// savitzky_golay_smoother_unit: streaming savitzky-golay smoother
// 7-tap cubic or 9-tap quintic smoothing of a signed sample stream
// ----------------------------------------------------------------------------
// One smoothed sample leaves for every sample taken, one item per clock
// cycle when the output side keeps up. The nine-cell transposed tap chain
// registers the finished tap sum at the accepting edge, the reciprocal
// multiply then registers the product, and rounding and saturation fill the
// output register, from which the result shows on m_tdata. The whole pipeline
// advances together, so s_tready is low whenever the output register holds an
// item that m_tready does not take. Reset clears the chain, which makes the
// first results see zero history. cfg_data picks the filter (0 cubic over 21,
// 1 quintic over 429), and a change applies to the stored history at once.
// ----------------------------------------------------------------------------
module savitzky_golay_smoother_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,     // filter_choice
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,      // sample_in
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,      // smoothed_out
    output logic             m_tuser       // clipped
);
    import sgs_pkg::*;

    filter_t filter_reg;
    logic    v1_reg, v2_reg, vout_reg;
    logic    advance;
    logic    accept;
    sum_t    acc7 [NUM_CELLS+1];
    sum_t    acc9 [NUM_CELLS+1];
    sum_t    tap_sum;
    sample_t smoothed;

    assign cfg_ready = 1'b1;
    assign advance   = !vout_reg || m_tready;
    assign s_tready  = advance;
    assign accept    = s_tvalid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_reg <= FILTER_CUBIC7;
        end
        else if (cfg_valid)
        begin
            filter_reg <= filter_t'(cfg_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            vout_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            vout_reg <= v2_reg;
        end
    end

    assign acc7[NUM_CELLS] = '0;
    assign acc9[NUM_CELLS] = '0;

    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        sgs_cell u_cell
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift_en (accept),
            .sample   (sample_t'(s_tdata)),
            .tap7     (tap7(k)),
            .tap9     (tap9(k)),
            .acc7_in  (acc7[k+1]),
            .acc9_in  (acc9[k+1]),
            .acc7     (acc7[k]),
            .acc9     (acc9[k])
        );
    end

    always_comb
    begin
        case (filter_reg)
            FILTER_CUBIC7:   tap_sum = acc7[0];
            FILTER_QUINTIC9: tap_sum = acc9[0];
            default:         tap_sum = acc7[0];
        endcase
    end

    sgs_scaler u_scaler
    (
        .clk          (clk),
        .advance      (advance),
        .filter_sel   (filter_reg),
        .tap_sum      (tap_sum),
        .smoothed_out (smoothed),
        .clipped      (m_tuser)
    );

    assign m_tvalid = vout_reg;
    assign m_tdata  = smoothed;

    // the cubic chain never reaches the last two cells
    a_cubic_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc7[NUM_CELLS-2] == '0) && (acc7[NUM_CELLS-1] == '0))
        else $error("cubic tail cell holds a nonzero partial sum");

    a_clip_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata == 16'h7fff || m_tdata == 16'h8000))
        else $error("clipped item not at a range limit");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted item lost in the tap chain");

    a_stage_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && advance) |=> m_tvalid)
        else $error("scaled item did not reach the output");

endmodule
`default_nettype wire
